[hdl/pclfu_pkg.sv]
// Package for the piece cache replacement block.
// Holds field widths, piece addressing constants, the sequencer states and
// the control structs shared with the recent-insert FIFO. No dependencies.
`default_nettype none

package pclfu_pkg;

    localparam int ADDR_W        = 28;
    localparam int PIECE_W       = 16;
    localparam int COUNT_W       = 16;
    localparam int PIECE_BYTES   = 4096;
    localparam int PIECE_SHIFT   = $clog2(PIECE_BYTES);
    localparam int PIECE_ID_BITS = 16;

    localparam logic [PIECE_W-1:0] ID_MASK = PIECE_W'((64'd1 << PIECE_ID_BITS) - 64'd1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_POP_VICTIM,
        ST_POP_READ,
        ST_SWEEP,
        ST_INSERT,
        ST_FIFO_POP,
        ST_FIFO_PUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

`default_nettype wire

[hdl/pclfu_recent_fifo.sv]
// Circular FIFO of the slot indices of the most recently inserted pieces.
// Depends on pclfu_pkg for the command and status structs.
`default_nettype none

module pclfu_recent_fifo
    import pclfu_pkg::*;
#(
    parameter int DEPTH  = 10,
    parameter int SLOT_W = 5
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fifo_cmd_t         cmd,
    input  wire logic [SLOT_W-1:0] push_slot,
    output logic      [SLOT_W-1:0] front_slot,
    output fifo_stat_t             stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [SLOT_W-1:0] fifo_mem [DEPTH];
    logic [SLOT_W-1:0] front_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign do_pop = cmd.pop && (count_reg != '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next = ptr_inc(tail_reg);
        end
        if (do_pop)
        begin
            head_next = ptr_inc(head_reg);
        end
        if (cmd.push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!cmd.push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The front entry is read through a register; it settles in the cycle
    // after the head pointer or the entry under it changes.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            fifo_mem[tail_reg] <= push_slot;
        front_reg <= fifo_mem[head_reg];
    end

    assign front_slot = front_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

[hdl/piece_cache_lfu_replacement.sv]
// Piece cache replacement: LFU with protection of the recently inserted pieces.
// One slot is visited per cycle in scan and sweep. One transfer is handled at a time;
// a new one is accepted in the cycle after the result loads.
// Reset clears the occupancy count and the FIFO pointers; no clearing pass is run.
`default_nettype none

module piece_cache_lfu_replacement
    import pclfu_pkg::*;
#(
    parameter int CACHE_ENTRIES  = 32,
    parameter int RECENT_ENTRIES = 10
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [ADDR_W-1:0]  record_address,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [PIECE_W-1:0] piece_number,
    output logic                    header_access,
    output logic                    hit,
    output logic                    evicted,
    output logic      [PIECE_W-1:0] evicted_piece
);

    // Slot indices, and counts that must also hold the slot total itself.
    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    // Slots are filled in index order and an evicted slot is refilled by the
    // same transfer, so slot i holds a piece exactly when i < occ_reg. That
    // replaces per-slot valid bits, and the slot arrays need no reset.
    logic [PIECE_W-1:0] piece_mem  [CACHE_ENTRIES];
    logic [COUNT_W-1:0] count_mem  [CACHE_ENTRIES];
    logic [IDX_W-1:0]   age_mem    [CACHE_ENTRIES];
    logic               recent_mem [CACHE_ENTRIES];

    logic [PIECE_W-1:0] piece_rd_reg;
    logic [COUNT_W-1:0] count_rd_reg;
    logic [IDX_W-1:0]   age_rd_reg;
    logic               recent_rd_reg;

    // Sequencer and control state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               out_valid_reg, out_valid_next;

    // Per-transfer working registers.
    logic [PIECE_W-1:0] piece_reg, piece_next;
    logic               header_reg, header_next;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic               best_found_reg, best_found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    logic [IDX_W-1:0]   best_age_reg, best_age_next;
    logic [PIECE_W-1:0] best_piece_reg, best_piece_next;
    logic [IDX_W-1:0]   target_reg, target_next;
    logic [IDX_W-1:0]   age_t_reg, age_t_next;
    logic               evicted_reg, evicted_next;
    logic [PIECE_W-1:0] ev_piece_reg, ev_piece_next;

    // Result register on the output side.
    logic [PIECE_W-1:0] out_piece_reg, out_piece_next;
    logic               out_header_reg, out_header_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_evicted_reg, out_evicted_next;
    logic [PIECE_W-1:0] out_ev_piece_reg, out_ev_piece_next;

    // Memory access controls.
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_issue;
    logic               piece_we;
    logic               count_we;
    logic [IDX_W-1:0]   count_waddr;
    logic [COUNT_W-1:0] count_wdata;
    logic               age_we;
    logic [IDX_W-1:0]   age_waddr;
    logic [IDX_W-1:0]   age_wdata;
    logic               recent_we;
    logic [IDX_W-1:0]   recent_waddr;
    logic               recent_wdata;

    logic [PIECE_W-1:0] piece_comb;
    logic [CNT_W-1:0]   insert_age;
    logic               better;

    fifo_cmd_t          fifo_cmd;
    fifo_stat_t         fifo_stat;
    logic [IDX_W-1:0]   front_slot;

    pclfu_recent_fifo #(
        .DEPTH  (RECENT_ENTRIES),
        .SLOT_W (IDX_W)
    ) u_recent_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (fifo_cmd),
        .push_slot  (target_reg),
        .front_slot (front_slot),
        .stat       (fifo_stat)
    );

    // The piece size is a power of two, so the division is a shift.
    assign piece_comb = PIECE_W'(record_address >> PIECE_SHIFT) & ID_MASK;

    // The compare unit: does the slot coming out of the memories beat
    // the current victim candidate? Lower use count wins, then older insert.
    assign better = !recent_rd_reg &&
                    (!best_found_reg ||
                     (count_rd_reg < best_count_reg) ||
                     ((count_rd_reg == best_count_reg) && (age_rd_reg < best_age_reg)));

    // A fresh piece takes the rank equal to the occupancy before it is added;
    // after an eviction that is one below the full count.
    assign insert_age = evicted_reg ? (occ_reg - 1'b1) : occ_reg;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        scan_idx_next     = scan_idx_reg;
        out_valid_next    = out_valid_reg && out_stall;
        piece_next        = piece_reg;
        header_next       = header_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_count_next    = hit_count_reg;
        best_found_next   = best_found_reg;
        best_idx_next     = best_idx_reg;
        best_count_next   = best_count_reg;
        best_age_next     = best_age_reg;
        best_piece_next   = best_piece_reg;
        target_next       = target_reg;
        age_t_next        = age_t_reg;
        evicted_next      = evicted_reg;
        ev_piece_next     = ev_piece_reg;
        out_piece_next    = out_piece_reg;
        out_header_next   = out_header_reg;
        out_hit_next      = out_hit_reg;
        out_evicted_next  = out_evicted_reg;
        out_ev_piece_next = out_ev_piece_reg;

        rd_addr      = scan_idx_reg[IDX_W-1:0];
        rd_issue     = 1'b0;
        piece_we     = 1'b0;
        count_we     = 1'b0;
        count_waddr  = target_reg;
        count_wdata  = '0;
        age_we       = 1'b0;
        age_waddr    = target_reg;
        age_wdata    = insert_age[IDX_W-1:0];
        recent_we    = 1'b0;
        recent_waddr = target_reg;
        recent_wdata = 1'b1;
        fifo_cmd     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    piece_next      = piece_comb;
                    header_next     = (piece_comb == '0);
                    hit_found_next  = 1'b0;
                    best_found_next = 1'b0;
                    evicted_next    = 1'b0;
                    ev_piece_next   = '0;
                    scan_idx_next   = '0;
                    // The header piece is never cached and leaves the state alone.
                    state_next      = (piece_comb == '0) ? ST_DONE : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // One occupied slot is read per cycle; the compare works on the
                // slot read in the previous cycle.
                if (scan_idx_reg < occ_reg)
                begin
                    rd_issue      = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_DECIDE;
                end
                if (rd_valid_reg)
                begin
                    if (piece_rd_reg == piece_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_count_next = count_rd_reg;
                    end
                    if (better)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_count_next = count_rd_reg;
                        best_age_next   = age_rd_reg;
                        best_piece_next = piece_rd_reg;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (hit_found_reg)
                begin
                    // The use count wraps at its width.
                    count_we    = 1'b1;
                    count_waddr = hit_idx_reg;
                    count_wdata = hit_count_reg + 1'b1;
                    state_next  = ST_DONE;
                end
                else if (occ_reg < CNT_W'(CACHE_ENTRIES))
                begin
                    target_next = occ_reg[IDX_W-1:0];
                    state_next  = ST_INSERT;
                end
                else
                begin
                    evicted_next = 1'b1;
                    if (best_found_reg)
                    begin
                        target_next   = best_idx_reg;
                        ev_piece_next = best_piece_reg;
                        age_t_next    = best_age_reg;
                        scan_idx_next = '0;
                        state_next    = ST_SWEEP;
                    end
                    else
                    begin
                        // Every slot is protected: the oldest recent one goes.
                        state_next = ST_POP_VICTIM;
                    end
                end
            end

            ST_POP_VICTIM:
            begin
                fifo_cmd.pop = 1'b1;
                recent_we    = 1'b1;
                recent_waddr = front_slot;
                recent_wdata = 1'b0;
                rd_addr      = front_slot;
                target_next  = front_slot;
                state_next   = ST_POP_READ;
            end

            ST_POP_READ:
            begin
                ev_piece_next = piece_rd_reg;
                age_t_next    = age_rd_reg;
                scan_idx_next = '0;
                state_next    = ST_SWEEP;
            end

            ST_SWEEP:
            begin
                // Close the gap in the insertion ranks left by the victim.
                if (scan_idx_reg < occ_reg)
                begin
                    rd_issue      = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_INSERT;
                end
                if (rd_valid_reg && (age_rd_reg > age_t_reg))
                begin
                    age_we    = 1'b1;
                    age_waddr = rd_idx_reg;
                    age_wdata = age_rd_reg - 1'b1;
                end
            end

            ST_INSERT:
            begin
                piece_we   = 1'b1;
                count_we   = 1'b1;
                age_we     = 1'b1;
                occ_next   = evicted_reg ? occ_reg : (occ_reg + 1'b1);
                state_next = fifo_stat.full ? ST_FIFO_POP : ST_FIFO_PUSH;
            end

            ST_FIFO_POP:
            begin
                fifo_cmd.pop = 1'b1;
                recent_we    = 1'b1;
                recent_waddr = front_slot;
                recent_wdata = 1'b0;
                state_next   = ST_FIFO_PUSH;
            end

            ST_FIFO_PUSH:
            begin
                fifo_cmd.push = 1'b1;
                recent_we     = 1'b1;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                // The result register frees up as soon as its transfer completes.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_piece_next    = piece_reg;
                    out_header_next   = header_reg;
                    out_hit_next      = hit_found_reg;
                    out_evicted_next  = evicted_reg;
                    out_ev_piece_next = ev_piece_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_valid_next = rd_issue;
        rd_idx_next   = rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            scan_idx_reg  <= scan_idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg       <= rd_idx_next;
        piece_reg        <= piece_next;
        header_reg       <= header_next;
        hit_found_reg    <= hit_found_next;
        hit_idx_reg      <= hit_idx_next;
        hit_count_reg    <= hit_count_next;
        best_found_reg   <= best_found_next;
        best_idx_reg     <= best_idx_next;
        best_count_reg   <= best_count_next;
        best_age_reg     <= best_age_next;
        best_piece_reg   <= best_piece_next;
        target_reg       <= target_next;
        age_t_reg        <= age_t_next;
        evicted_reg      <= evicted_next;
        ev_piece_reg     <= ev_piece_next;
        out_piece_reg    <= out_piece_next;
        out_header_reg   <= out_header_next;
        out_hit_reg      <= out_hit_next;
        out_evicted_reg  <= out_evicted_next;
        out_ev_piece_reg <= out_ev_piece_next;
    end

    // Slot arrays: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (piece_we)
            piece_mem[target_reg] <= piece_reg;
        piece_rd_reg <= piece_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (count_we)
            count_mem[count_waddr] <= count_wdata;
        count_rd_reg <= count_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (age_we)
            age_mem[age_waddr] <= age_wdata;
        age_rd_reg <= age_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (recent_we)
            recent_mem[recent_waddr] <= recent_wdata;
        recent_rd_reg <= recent_mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign piece_number  = out_piece_reg;
    assign header_access = out_header_reg;
    assign hit           = out_hit_reg;
    assign evicted       = out_evicted_reg;
    assign evicted_piece = out_ev_piece_reg;

    // A header transfer reports neither a hit nor an eviction.
    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_access) |-> (!hit && !evicted && (evicted_piece == '0)))
        else $error("header transfer reports cache activity");

    // Evictions only happen once every slot is occupied, and never on a hit.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> ((occ_reg == CNT_W'(CACHE_ENTRIES)) && !hit))
        else $error("eviction reported while the cache is not full");

    // Occupancy never exceeds the slot count.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CACHE_ENTRIES))
        else $error("occupancy beyond slot count");

    // A new result appears only out of the completion state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside completion");

    // A hit does not change the occupancy.
    a_hit_occ: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && hit_found_reg) |=> $stable(occ_reg))
        else $error("hit changed occupancy");

    // When every slot is protected, the FIFO holds them all and has a front entry.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_VICTIM) |-> !fifo_stat.empty)
        else $error("victim taken from an empty recent FIFO");

endmodule

`default_nettype wire
